/* hw/rtl/dcd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the double clap detector.
// No dependencies; every other file depends on this package.
package dcd_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned THR_BITS    = SAMPLE_BITS + 1;
  localparam int unsigned TICK_BITS   = 16;
  localparam int unsigned AVG_LEN_DEF = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AVERAGE_STEP     = 2'd0,
    CFG_THRESHOLD_MARGIN = 2'd1,
    CFG_MAX_GAP          = 2'd2,
    CFG_MIN_GAP          = 2'd3
  } cfg_idx_e;

  localparam logic [SAMPLE_BITS-1:0] AVERAGE_STEP_RST     = SAMPLE_BITS'(50);
  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_MARGIN_RST = SAMPLE_BITS'(150);
  localparam logic [TICK_BITS-1:0]   MAX_GAP_RST          = TICK_BITS'(20000);
  localparam logic [TICK_BITS-1:0]   MIN_GAP_RST          = TICK_BITS'(1000);

  // no clap can fire until the first average update
  localparam logic [THR_BITS-1:0] THRESHOLD_RST = THR_BITS'((1 << SAMPLE_BITS) - 1);

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [SAMPLE_BITS-1:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic                   double_clap;
    logic                   clap;
    logic [SAMPLE_BITS-1:0] average_level;
    logic [THR_BITS-1:0]    threshold;
  } out_beat_t;

  // controls from the sequencer into the history chain
  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctrl_t;

endpackage

/* hw/rtl/dcd_if.sv */
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the input and result beats.
// Depends on dcd_pkg.
interface dcd_in_if;
  logic               valid;
  logic               ready;
  dcd_pkg::in_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dcd_out_if;
  logic               valid;
  logic               ready;
  dcd_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/dcd_cell.sv */
`timescale 1ns / 1ps
// One history entry of the sample chain.
// Depends on dcd_pkg.
module dcd_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            shift_i,
  input  logic [dcd_pkg::SAMPLE_BITS-1:0] d_i,
  output logic [dcd_pkg::SAMPLE_BITS-1:0] q_o
);
  import dcd_pkg::*;

  logic [SAMPLE_BITS-1:0] entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

/* hw/rtl/dcd_chain.sv */
`timescale 1ns / 1ps
// Circular chain of history cells; the head cell feeds the summing logic.
// Depends on dcd_pkg and dcd_cell.
module dcd_chain #(
  parameter int unsigned AVG_LEN = dcd_pkg::AVG_LEN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dcd_pkg::chain_ctrl_t            ctrl_i,
  input  logic [dcd_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic [dcd_pkg::SAMPLE_BITS-1:0] head_o
);
  import dcd_pkg::*;

  logic [SAMPLE_BITS-1:0] cell_q [AVG_LEN];
  logic [SAMPLE_BITS-1:0] cell_d [AVG_LEN];

  for (genvar i = 0; i < AVG_LEN; i++) begin : g_cell
    if (i == AVG_LEN - 1) begin : g_tail
      // drop the head and take the new sample, or recirculate the head
      assign cell_d[i] = ctrl_i.load ? sample_i : cell_q[0];
    end else begin : g_body
      assign cell_d[i] = cell_q[i+1];
    end

    dcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ctrl_i.shift),
      .d_i     (cell_d[i]),
      .q_o     (cell_q[i])
    );
  end

  assign head_o = cell_q[0];

endmodule

/* hw/rtl/double_clap_detector_core.sv */
`timescale 1ns / 1ps
// Double clap detector: history chain, sequencer, mean and clap decision.
// Tick beat: result registered in the cycle after acceptance; the next beat is accepted
// once the output register is free or the receiver takes the result. Sample beat: a load
// shift, AVG_LEN-1 chain shifts to sum the history, one multiply by the reciprocal of
// AVG_LEN and one update, then the result is registered; no new beat until back in idle.
// Reset is asynchronous and clears history, averages, timers and registers to defaults.
module double_clap_detector_core #(
  parameter int unsigned AVG_LEN = dcd_pkg::AVG_LEN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dcd_in_if.sink                         in_if,
  dcd_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [dcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dcd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dcd_pkg::*;

  localparam int unsigned LEN_BITS = $clog2(AVG_LEN);
  localparam int unsigned SUM_W    = SAMPLE_BITS + LEN_BITS;
  localparam int unsigned RECIP_SH = SUM_W + LEN_BITS;
  localparam int unsigned RECIP_W  = SUM_W + 1;
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_INT =
    ((64'd1 << RECIP_SH) + AVG_LEN - 1) / AVG_LEN;
  localparam logic [RECIP_W-1:0]  RECIP    = RECIP_W'(RECIP_INT);
  localparam logic [LEN_BITS-1:0] CNT_LAST = LEN_BITS'(AVG_LEN - 2);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [SAMPLE_BITS-1:0] avg_step_q, margin_q;
  logic [TICK_BITS-1:0]   max_gap_q, min_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_step_q <= AVERAGE_STEP_RST;
      margin_q   <= THRESHOLD_MARGIN_RST;
      max_gap_q  <= MAX_GAP_RST;
      min_gap_q  <= MIN_GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_AVERAGE_STEP:     avg_step_q <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_THRESHOLD_MARGIN: margin_q   <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_MAX_GAP:          max_gap_q  <= cfg_data_i[TICK_BITS-1:0];
        CFG_MIN_GAP:          min_gap_q  <= cfg_data_i[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  logic       out_valid_q;
  out_beat_t  out_data_q;
  logic       in_fire, in_sample, in_tick;

  assign in_if.ready = (state_q == ST_IDLE) && (!out_valid_q || out_if.ready);
  assign in_fire     = in_if.valid && in_if.ready;
  assign in_sample   = in_fire && (in_if.data.req_type == REQ_SAMPLE);
  assign in_tick     = in_fire && (in_if.data.req_type == REQ_TICK);

  // history chain
  chain_ctrl_t            chain_ctrl;
  logic [SAMPLE_BITS-1:0] head;

  dcd_chain #(
    .AVG_LEN (AVG_LEN)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (chain_ctrl),
    .sample_i (in_if.data.sample),
    .head_o   (head)
  );

  // datapath state
  logic [LEN_BITS-1:0]    cnt_q;
  logic [SUM_W-1:0]       acc_q;
  logic [PROD_W-1:0]      prod_q;
  logic                   clap_q, dbl_q;
  logic [SAMPLE_BITS-1:0] avg_q, avg_d;
  logic [THR_BITS-1:0]    thr_q, thr_d;
  logic [TICK_BITS-1:0]   tick_q, last_clap_q;
  logic [TICK_BITS-1:0]   gap;
  logic                   is_clap;
  logic [SAMPLE_BITS-1:0] mean, diff;

  assign gap     = tick_q - last_clap_q;
  assign is_clap = {1'b0, in_if.data.sample} > thr_q;

  assign mean = prod_q[RECIP_SH +: SAMPLE_BITS];
  assign diff = (mean > avg_q) ? (mean - avg_q) : (avg_q - mean);

  // sum is at most 2*4095, so the threshold never needs saturation
  always_comb begin
    avg_d = avg_q;
    thr_d = thr_q;
    if (diff > avg_step_q) begin
      avg_d = mean;
      thr_d = {1'b0, mean} + {1'b0, margin_q};
    end
  end

  always_comb begin
    state_d          = state_q;
    chain_ctrl.shift = 1'b0;
    chain_ctrl.load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_sample) begin
          chain_ctrl.shift = 1'b1;
          chain_ctrl.load  = 1'b1;
          state_d          = ST_SUM;
        end
      end
      ST_SUM: begin
        chain_ctrl.shift = 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        // advance the write position unless the sample was a clap
        chain_ctrl.shift = !clap_q;
        state_d          = ST_FIN;
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      avg_q       <= '0;
      thr_q       <= THRESHOLD_RST;
      tick_q      <= '0;
      last_clap_q <= '0;
      clap_q      <= 1'b0;
      dbl_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_tick || (state_q == ST_FIN)) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_tick) begin
        tick_q <= tick_q + 1'b1;
      end
      if (in_sample) begin
        cnt_q  <= '0;
        clap_q <= is_clap;
        dbl_q  <= is_clap && (gap <= max_gap_q) && (gap > min_gap_q);
        if (is_clap) begin
          last_clap_q <= tick_q;
        end
      end
      if (state_q == ST_SUM) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == ST_FIN) begin
        avg_q <= avg_d;
        thr_q <= thr_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_sample) begin
      acc_q <= SUM_W'(in_if.data.sample);
    end else if (state_q == ST_SUM) begin
      acc_q <= acc_q + SUM_W'(head);
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(acc_q) * PROD_W'(RECIP);
    end
    if (in_tick) begin
      out_data_q.double_clap   <= 1'b0;
      out_data_q.clap          <= 1'b0;
      out_data_q.average_level <= avg_q;
      out_data_q.threshold     <= thr_q;
    end else if (state_q == ST_FIN) begin
      out_data_q.double_clap   <= dbl_q;
      out_data_q.clap          <= clap_q;
      out_data_q.average_level <= avg_d;
      out_data_q.threshold     <= thr_d;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> !out_valid_q)
    else $error("result ready while the output register is still full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sample |=> (state_q == ST_SUM))
    else $error("accepted sample did not start the history sum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_tick |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("tick beat did not produce a result at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    thr_q >= {1'b0, avg_q})
    else $error("threshold fell below the kept average");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_if.ready)
    else $error("input ready while a sample is in progress");

endmodule

/* tb/sv/clap_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the double clap detector: watches the beat and result channels
// and the register port, predicts every result beat and compares it field by field.
// Depends on dcd_pkg and the stream interfaces in dcd_if.
module clap_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dcd_in_if                              beat_ch,
  dcd_out_if                             res_ch,
  input  logic                           cfg_we_i,
  input  logic [dcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             due_count_o
);
  import dcd_pkg::*;

  localparam int unsigned RING_LEN = AVG_LEN_DEF;
  localparam int unsigned THR_MAX  = (1 << THR_BITS) - 1;

  logic [SAMPLE_BITS-1:0] ring [RING_LEN];
  int unsigned            ring_wr;
  logic [SAMPLE_BITS-1:0] avg_level;
  logic [THR_BITS-1:0]    clap_thr;
  logic [TICK_BITS-1:0]   tick_now;
  logic [TICK_BITS-1:0]   last_clap;
  logic [SAMPLE_BITS-1:0] step_reg;
  logic [SAMPLE_BITS-1:0] margin_reg;
  logic [TICK_BITS-1:0]   max_gap_reg;
  logic [TICK_BITS-1:0]   min_gap_reg;
  out_beat_t              reports_due [$];
  int                     fails;

  task automatic predict_report(input in_beat_t beat);
    out_beat_t            res;
    int unsigned          total;
    int unsigned          mean;
    int unsigned          spread;
    int unsigned          raised;
    int unsigned          slot;
    logic [THR_BITS-1:0]  prior_thr;
    logic [TICK_BITS-1:0] gap;
    res = '0;
    if (beat.req_type == REQ_TICK) begin
      tick_now = tick_now + 1'b1;
    end else begin
      prior_thr = clap_thr;
      ring[ring_wr] = beat.sample;
      ring_wr = (ring_wr == RING_LEN - 1) ? 0 : ring_wr + 1;
      total = 0;
      for (slot = 0; slot < RING_LEN; slot++) total += ring[slot];
      mean = total / RING_LEN;
      spread = (mean > avg_level) ? mean - avg_level : avg_level - mean;
      if (spread > step_reg) begin
        avg_level = SAMPLE_BITS'(mean);
        raised = 32'(avg_level) + 32'(margin_reg);
        clap_thr = (raised > THR_MAX) ? THR_BITS'(THR_MAX) : THR_BITS'(raised);
      end
      // a clap still counts in this mean; only its ring slot is given back
      if (beat.sample > prior_thr) begin
        res.clap = 1'b1;
        ring_wr = (ring_wr == 0) ? RING_LEN - 1 : ring_wr - 1;
        gap = tick_now - last_clap;
        res.double_clap = (gap <= max_gap_reg) && (gap > min_gap_reg);
        last_clap = tick_now;
      end
    end
    res.average_level = avg_level;
    res.threshold     = clap_thr;
    reports_due.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_beat_t   want;
    int unsigned slot;
    if (!rst_ni) begin
      for (slot = 0; slot < RING_LEN; slot++) ring[slot] = '0;
      ring_wr     = 0;
      avg_level   = '0;
      clap_thr    = THRESHOLD_RST;
      tick_now    = '0;
      last_clap   = '0;
      step_reg    = AVERAGE_STEP_RST;
      margin_reg  = THRESHOLD_MARGIN_RST;
      max_gap_reg = MAX_GAP_RST;
      min_gap_reg = MIN_GAP_RST;
      reports_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_AVERAGE_STEP:     step_reg    = cfg_data_i[SAMPLE_BITS-1:0];
          CFG_THRESHOLD_MARGIN: margin_reg  = cfg_data_i[SAMPLE_BITS-1:0];
          CFG_MAX_GAP:          max_gap_reg = cfg_data_i[TICK_BITS-1:0];
          CFG_MIN_GAP:          min_gap_reg = cfg_data_i[TICK_BITS-1:0];
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        if (reports_due.size() == 0) begin
          $display("%0t: result beat with none due: expected nothing, got %p",
                   $time, res_ch.data);
          fails++;
        end else begin
          want = reports_due.pop_front();
          check_field("double_clap", 16'(want.double_clap), 16'(res_ch.data.double_clap));
          check_field("clap", 16'(want.clap), 16'(res_ch.data.clap));
          check_field("average_level", 16'(want.average_level),
                      16'(res_ch.data.average_level));
          check_field("threshold", 16'(want.threshold), 16'(res_ch.data.threshold));
        end
      end
      if (beat_ch.valid && beat_ch.ready) predict_report(beat_ch.data);
    end
    fail_count_o = fails;
    due_count_o  = reports_due.size();
  end

endmodule

/* tb/sv/double_clap_detector_core_tb.sv */
`timescale 1ns / 1ps
// Top of the double clap detector testbench: clock, reset, beat and register stimulus,
// receiver stalls and the verdict. Depends on dcd_pkg, dcd_if, the core and clap_result_checker.
module double_clap_detector_core_tb;
  import dcd_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    due_count;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  int                    rx_hold_req;
  int unsigned           beats_sent;

  dcd_in_if  in_ch ();
  dcd_out_if out_ch ();

  double_clap_detector_core DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  clap_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .beat_ch      (in_ch),
    .res_ch       (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .due_count_o  (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[double_clap_detector_core] ERROR");
    $finish;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        rx_hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // enter and leave at a falling edge; valid stays high after the beat
  task automatic send_beat(input logic kind, input logic [SAMPLE_BITS-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{req_type: kind, sample: smp};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_level(input int unsigned lvl);
    send_beat(REQ_SAMPLE, (lvl > 4095) ? SAMPLE_BITS'(4095) : SAMPLE_BITS'(lvl));
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_beat(REQ_TICK, SAMPLE_BITS'($urandom));
  endtask

  // drop valid and hold until every result beat is in
  task automatic settle();
    in_ch.valid <= 1'b0;
    wait (due_count == 0);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [SAMPLE_BITS-1:0] step,
                                input logic [SAMPLE_BITS-1:0] margin,
                                input logic [TICK_BITS-1:0]   hi_gap,
                                input logic [TICK_BITS-1:0]   lo_gap);
    settle();
    write_reg(CFG_AVERAGE_STEP, {(CFG_DATA_W-SAMPLE_BITS)'($urandom), step});
    write_reg(CFG_THRESHOLD_MARGIN, {(CFG_DATA_W-SAMPLE_BITS)'($urandom), margin});
    write_reg(CFG_MAX_GAP, hi_gap);
    write_reg(CFG_MIN_GAP, lo_gap);
  endtask

  task automatic random_settings();
    logic [SAMPLE_BITS-1:0] step;
    logic [SAMPLE_BITS-1:0] margin;
    logic [TICK_BITS-1:0]   lo;
    logic [TICK_BITS-1:0]   hi;
    case ($urandom_range(5))
      0:       step = '0;
      1:       step = '1;
      default: step = SAMPLE_BITS'($urandom_range(80));
    endcase
    case ($urandom_range(5))
      0:       margin = '0;
      1:       margin = '1;
      default: margin = SAMPLE_BITS'($urandom_range(400));
    endcase
    case ($urandom_range(7))
      0:       lo = '0;
      1:       lo = '1;
      default: lo = TICK_BITS'($urandom_range(25));
    endcase
    case ($urandom_range(7))
      0:       hi = '0;
      1:       hi = '1;
      default: hi = lo + TICK_BITS'($urandom_range(40));
    endcase
    apply_settings(step, margin, hi, lo);
  endtask

  // background level, then one to three loud beats with tick gaps between them
  task automatic clap_episode();
    int unsigned quiet;
    int unsigned floor_lvl;
    int unsigned jitter;
    quiet     = $urandom_range(20, 2);
    floor_lvl = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(600);
    jitter    = $urandom_range(200);
    repeat (quiet) begin
      send_level(floor_lvl + $urandom_range(jitter));
      if ($urandom_range(5) == 0) send_ticks($urandom_range(3));
    end
    repeat ($urandom_range(3, 1)) begin
      send_ticks($urandom_range(60));
      send_level($urandom_range(4095, 2500));
      if ($urandom_range(2) == 0) send_level(floor_lvl + $urandom_range(jitter));
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(10, 1)) send_beat(1'($urandom), SAMPLE_BITS'($urandom));
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned goal;
    int unsigned group_end;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    send_idle_pct = 33;
    recv_idle_pct = 86;
    rx_hold_req   = 0;
    beats_sent    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_beat(REQ_TICK, '1);
    send_level(0);
    send_level(4095);  // full scale, yet not above the reset threshold
    send_level(4095);  // clap, gap far below the minimum
    apply_settings(AVERAGE_STEP_RST, THRESHOLD_MARGIN_RST, 16'd5, 16'd2);
    send_ticks(3);
    send_level(4095);  // double clap
    send_ticks(6);
    send_level(4095);  // gap above the maximum
    send_ticks(5);
    send_level(4095);  // gap equal to the maximum still counts
    send_ticks(2);
    send_level(4095);  // gap equal to the minimum does not

    // drive the threshold to its top value
    apply_settings('0, '1, '1, '0);
    repeat (20) send_level(4095);

    // long receiver hold-off while beats keep coming
    rx_hold_req = 1;
    repeat (30) send_level($urandom_range(4095));

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 33 : 0;
      goal = beats_sent + 300;
      while (beats_sent < goal) begin
        random_settings();
        group_end = beats_sent + 100;
        while ((beats_sent < group_end) && (beats_sent < goal)) begin
          if ($urandom_range(4) == 0) noise_burst();
          else clap_episode();
        end
      end
    end

    in_ch.valid <= 1'b0;
    wait (due_count == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[double_clap_detector_core] OK");
    end else begin
      $display("[double_clap_detector_core] ERROR");
    end
    $finish;
  end

endmodule
